// File: rtl/core/bis_pkg.sv
`default_nettype none
package bis_pkg;

  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned MaxHeight   = 64;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned StoreDepth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_TGT_W  = 3'd2,
    REG_TGT_H  = 3'd3,
    REG_CHAN   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
    logic [7:0] pixel_ch3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_ch0;
    logic [7:0] result_ch1;
    logic [7:0] result_ch2;
    logic [7:0] result_ch3;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [31:0]      word;
    logic [6:0]       srcw;
    logic [6:0]       xl;
    logic [6:0]       xh;
    logic [6:0]       yl;
    logic [6:0]       yh;
    logic [7:0]       xf;
    logic [7:0]       yf;
    logic [2:0]       chan;
    logic             row_end;
    logic             frame_end;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD0,
    BK_RD1,
    BK_RD2,
    BK_RD3,
    BK_CALC,
    BK_OUT
  } bk_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_e;

endpackage
`default_nettype wire

// File: rtl/core/bis_step_div.sv
`default_nettype none
module bis_step_div import bis_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [14:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             busy_o,
  output logic [14:0]      step_o
);

  div_state_e  state_q, state_d;
  logic [14:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] trial;
  logic [3:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign trial = {rem_q, quo_q[14]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      state_d = DV_RUN;
      quo_d   = num_i;
      rem_d   = '0;
      cnt_d   = '0;
    end else begin
      unique case (state_q)
        DV_IDLE, DV_DONE: ;
        DV_RUN: begin
          if (trial >= {1'b0, den_i}) begin
            rem_d = 16'(trial - {1'b0, den_i});
            quo_d = {quo_q[13:0], 1'b1};
          end else begin
            rem_d = trial[15:0];
            quo_d = {quo_q[13:0], 1'b0};
          end
          cnt_d = 4'(cnt_q + 4'd1);
          if (cnt_q == 4'd14) state_d = DV_DONE;
        end
        default: state_d = DV_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q == DV_RUN) || start_i;
  assign step_o = (quo_q == '0) ? 15'd1 : quo_q;

endmodule
`default_nettype wire

// File: rtl/core/bis_front.sv
`default_nettype none
module bis_front import bis_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  output logic                     cmd_valid_o,
  input  wire logic                cmd_ready_i,
  output cmd_t                     cmd_o
);

  logic [6:0]       src_w_q, src_h_q;
  logic [15:0]      tgt_w_q, tgt_h_q;
  logic [2:0]       chan_q;
  logic [AddrW-1:0] load_idx_q;
  logic [15:0]      col_cnt_q, row_cnt_q;
  logic [14:0]      col_acc_q, row_acc_q;
  logic             div_go_q;

  logic [6:0]  sw, sh;
  logic [15:0] tw, th;
  logic [2:0]  ch;
  logic [14:0] xmax, ymax, xa, ya;
  logic [6:0]  xl, yl;
  logic [12:0] total;
  logic [12:0] load_next;
  logic        cfg_hit, x_busy, y_busy;
  logic [14:0] x_step, y_step;
  logic [15:0] col_next;
  logic [15:0] x_sum, y_sum;
  logic        accept, is_emit, row_done, frame_done;

  assign sw = (src_w_q == '0) ? 7'd1 : (src_w_q > 7'(MaxWidth)) ? 7'(MaxWidth) : src_w_q;
  assign sh = (src_h_q == '0) ? 7'd1 : (src_h_q > 7'(MaxHeight)) ? 7'(MaxHeight) : src_h_q;
  assign tw = (tgt_w_q == '0) ? 16'd1 : tgt_w_q;
  assign th = (tgt_h_q == '0) ? 16'd1 : tgt_h_q;
  assign ch = (chan_q == '0) ? 3'd1 : (chan_q > 3'(MaxChannels)) ? 3'(MaxChannels) : chan_q;

  assign xmax = {7'(sw - 7'd1), 8'd0};
  assign ymax = {7'(sh - 7'd1), 8'd0};
  assign xa   = (col_acc_q > xmax) ? xmax : col_acc_q;
  assign ya   = (row_acc_q > ymax) ? ymax : row_acc_q;
  assign xl   = xa[14:8];
  assign yl   = ya[14:8];
  assign total = 13'(sw) * 13'(sh);

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CfgIdxW'(REG_CHAN));

  bis_step_div u_xdiv (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i({sw, 8'd0}), .den_i(tw),
    .busy_o(x_busy), .step_o(x_step));
  bis_step_div u_ydiv (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i({sh, 8'd0}), .den_i(th),
    .busy_o(y_busy), .step_o(y_step));

  assign is_emit    = (in_item_i.operation == OP_EMIT);
  assign in_ready_o = cmd_ready_i && !x_busy && !y_busy && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd_valid_o = in_valid_i && !x_busy && !y_busy && !cfg_we_i;

  assign col_next   = 16'(col_cnt_q + 16'd1);
  assign row_done   = (col_next >= tw);
  assign frame_done = row_done && (16'(row_cnt_q + 16'd1) >= th);
  assign x_sum      = 16'(xa) + 16'(x_step);
  assign y_sum      = 16'(ya) + 16'(y_step);
  assign load_next  = 13'(13'(load_idx_q) + 13'd1);

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = is_emit ? OP_EMIT : OP_LOAD;
    cmd_o.addr      = (13'(load_idx_q) >= total) ? '0 : load_idx_q;
    cmd_o.word      = {in_item_i.pixel_ch3, in_item_i.pixel_ch2,
                       in_item_i.pixel_ch1, in_item_i.pixel_ch0};
    cmd_o.srcw      = sw;
    cmd_o.xl        = xl;
    cmd_o.yl        = yl;
    cmd_o.xh        = (7'(xl + 7'd1) < sw) ? 7'(xl + 7'd1) : xl;
    cmd_o.yh        = (7'(yl + 7'd1) < sh) ? 7'(yl + 7'd1) : yl;
    cmd_o.xf        = xa[7:0];
    cmd_o.yf        = ya[7:0];
    cmd_o.chan      = ch;
    cmd_o.row_end   = row_done;
    cmd_o.frame_end = frame_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= 7'd64;
      src_h_q    <= 7'd64;
      tgt_w_q    <= 16'd64;
      tgt_h_q    <= 16'd64;
      chan_q     <= 3'd3;
      load_idx_q <= '0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      col_acc_q  <= '0;
      row_acc_q  <= '0;
      div_go_q   <= 1'b1;
    end else begin
      div_go_q <= cfg_hit;
      if (cfg_hit) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_SRC_W: src_w_q <= cfg_data_i[6:0];
          REG_SRC_H: src_h_q <= cfg_data_i[6:0];
          REG_TGT_W: tgt_w_q <= cfg_data_i;
          REG_TGT_H: tgt_h_q <= cfg_data_i;
          REG_CHAN:  chan_q  <= cfg_data_i[2:0];
          default: ;
        endcase
        load_idx_q <= '0;
        col_cnt_q  <= '0;
        row_cnt_q  <= '0;
        col_acc_q  <= '0;
        row_acc_q  <= '0;
      end else if (accept) begin
        if (!is_emit) begin
          if (13'(load_idx_q) >= total) load_idx_q <= ((13'd1 >= total) ? '0 : AddrW'(1));
          else load_idx_q <= (load_next >= total) ? '0 : AddrW'(load_next);
        end else begin
          if (row_done) begin
            col_cnt_q <= '0;
            col_acc_q <= '0;
            if (frame_done) begin
              row_cnt_q <= '0;
              row_acc_q <= '0;
            end else begin
              row_cnt_q <= 16'(row_cnt_q + 16'd1);
              row_acc_q <= (y_sum > 16'(ymax)) ? ymax : y_sum[14:0];
            end
          end else begin
            col_cnt_q <= col_next;
            col_acc_q <= (x_sum > 16'(xmax)) ? xmax : x_sum[14:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bis_queue.sv
`default_nettype none
module bis_queue import bis_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_o
);

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop_valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");

endmodule
`default_nettype wire

// File: rtl/core/bis_back.sv
`default_nettype none
module bis_back import bis_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  output logic           cmd_ready_o,
  input  wire cmd_t      cmd_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic [31:0]      mem [StoreDepth];
  bk_state_e        state_q, state_d;
  logic [31:0]      rdata_q;
  logic [31:0]      tl_q, tr_q, bl_q;
  logic [15:0]      top_q [4];
  logic [15:0]      bot_q [4];
  logic             hold_valid_q;
  out_item_t        hold_q;
  logic             mem_we, rd_en, hold_load;
  logic [8:0]       wx, wy;
  logic [7:0]       res [4];
  out_item_t        res_item;
  logic [AddrW-1:0] a_tl, a_tr, a_bl, a_br, a_sel;

  assign a_tl = AddrW'(cmd_i.yl) * AddrW'(cmd_i.srcw) + AddrW'(cmd_i.xl);
  assign a_tr = AddrW'(cmd_i.yl) * AddrW'(cmd_i.srcw) + AddrW'(cmd_i.xh);
  assign a_bl = AddrW'(cmd_i.yh) * AddrW'(cmd_i.srcw) + AddrW'(cmd_i.xl);
  assign a_br = AddrW'(cmd_i.yh) * AddrW'(cmd_i.srcw) + AddrW'(cmd_i.xh);

  assign wx = 9'd256 - 9'(cmd_i.xf);
  assign wy = 9'd256 - 9'(cmd_i.yf);

  assign mem_we    = (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.op == OP_LOAD);
  assign hold_load = (state_q == BK_OUT) && (!hold_valid_q || out_ready_i);

  always_comb begin
    rd_en = 1'b1;
    unique case (state_q)
      BK_RD0: a_sel = a_tl;
      BK_RD1: a_sel = a_tr;
      BK_RD2: a_sel = a_bl;
      BK_RD3: a_sel = a_br;
      default: begin
        a_sel = a_br;
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      hold_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (hold_load) hold_valid_q <= 1'b1;
      else if (out_ready_i) hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_i.addr] <= cmd_i.word;
    if (rd_en) rdata_q <= mem[a_sel];
    unique case (state_q)
      BK_RD1: tl_q <= rdata_q;
      BK_RD2: tr_q <= rdata_q;
      BK_RD3: bl_q <= rdata_q;
      BK_CALC: begin
        for (int k = 0; k < 4; k++) begin
          top_q[k] <= 16'(tl_q[8*k +: 8] * wx + tr_q[8*k +: 8] * cmd_i.xf);
          bot_q[k] <= 16'(bl_q[8*k +: 8] * wx + rdata_q[8*k +: 8] * cmd_i.xf);
        end
      end
      default: ;
    endcase
    if (hold_load) hold_q <= res_item;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      res[k] = (3'(k) < cmd_i.chan)
        ? 8'((32'(top_q[k]) * 32'(wy) + 32'(bot_q[k]) * 32'(cmd_i.yf) + 32'h8000) >> 16)
        : 8'd0;
    end
    res_item = '{result_ch0: res[0], result_ch1: res[1], result_ch2: res[2],
                 result_ch3: res[3], row_end: cmd_i.row_end,
                 frame_end: cmd_i.frame_end};
  end

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_LOAD) cmd_ready_o = 1'b1;
          else state_d = BK_RD0;
        end
      end
      BK_RD0:  state_d = BK_RD1;
      BK_RD1:  state_d = BK_RD2;
      BK_RD2:  state_d = BK_RD3;
      BK_RD3:  state_d = BK_CALC;
      BK_CALC: state_d = BK_OUT;
      BK_OUT: begin
        if (hold_load) begin
          cmd_ready_o = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign out_valid_o = hold_valid_q;
  assign out_item_o  = hold_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RD0) |=> (state_q == BK_RD1)) else $error("read sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> cmd_ready_o) else $error("load written but not popped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT) |-> cmd_valid_i) else $error("command lost mid emit");

endmodule
`default_nettype wire

// File: rtl/core/bilinear_image_scaler_core.sv
`default_nettype none
// Channel | Handshake            | Payload
// in      | in_valid_i/in_ready_o| in_item_i (in_item_t)
// out     | out_valid_o/out_ready_i | out_item_o (out_item_t)
// cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
// In the back end a load item is written and taken while idle; an emit reads the
// single-port frame store four times, then interpolates and registers the result.
// After reset and each write to a defined register the step dividers run; no item
// is taken while they are busy. Reset is asynchronous and active low.
// A full queue, or a result waiting in the output register, holds the input back.
module bilinear_image_scaler_core import bis_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_item_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  bis_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd));

  bis_queue u_queue (
    .clk_i, .rst_ni, .push_valid_i(f_valid), .push_ready_o(f_ready), .push_i(f_cmd),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_o(b_cmd));

  bis_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .out_item_o);

endmodule
`default_nettype wire

// File: tb/tb_bilinear_image_scaler_core.sv
`timescale 1ns / 1ps
module tb_bilinear_image_scaler_core;
  import bis_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;

  bilinear_image_scaler_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_item_i(in_item_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_item_o(out_item_o)
  );

  localparam int unsigned CycleLimit = 2000000;

  // Scaler state as the predictor sees it.
  logic [31:0] pixel_mem [StoreDepth];
  int unsigned load_pos, col_cnt, row_cnt, col_acc, row_acc;
  int unsigned src_w, src_h, tgt_w, tgt_h, chan_cnt;

  out_item_t   pixel_queue [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          stall_mode;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned step_q88(int unsigned src, int unsigned dst);
    int unsigned s;
    s = (src << 8) / dst;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic void predictor_restart();
    load_pos = 0;
    col_cnt = 0;
    row_cnt = 0;
    col_acc = 0;
    row_acc = 0;
  endfunction

  function automatic void predict_config(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      REG_SRC_W: src_w = 32'(val[6:0]);
      REG_SRC_H: src_h = 32'(val[6:0]);
      REG_TGT_W: tgt_w = 32'(val);
      REG_TGT_H: tgt_h = 32'(val);
      REG_CHAN:  chan_cnt = 32'(val[2:0]);
      default:   return;
    endcase
    predictor_restart();
  endfunction

  function automatic logic [31:0] pixel_at(int unsigned x, int unsigned y, int unsigned sw);
    int unsigned idx;
    idx = y * sw + x;
    return (idx < StoreDepth) ? pixel_mem[idx] : 32'h0;
  endfunction

  // Returns 1 and the interpolated pixel for an emit; loads return 0.
  function automatic bit scale_pixel(in_item_t it, output out_item_t res);
    int unsigned sw, sh, tw, th, ch, xmax, ymax, xl, xh, yl, yh, xf, yf;
    int unsigned k, a, b, c, d, top, bot, tot, v;
    logic [31:0] tl, tr, bl, br;
    logic [7:0]  lanes [4];
    sw = clampu(src_w, 1, MaxWidth);
    sh = clampu(src_h, 1, MaxHeight);
    tw = (tgt_w == 0) ? 1 : tgt_w;
    th = (tgt_h == 0) ? 1 : tgt_h;
    ch = clampu(chan_cnt, 1, MaxChannels);
    xmax = (sw - 1) << 8;
    ymax = (sh - 1) << 8;
    res = '0;
    if (op_e'(it.operation) == OP_LOAD) begin
      if (load_pos >= sw * sh) load_pos = 0;
      if (load_pos < StoreDepth)
        pixel_mem[load_pos] = {it.pixel_ch3, it.pixel_ch2, it.pixel_ch1, it.pixel_ch0};
      load_pos++;
      if (load_pos >= sw * sh) load_pos = 0;
      return 0;
    end
    if (col_acc > xmax) col_acc = xmax;
    if (row_acc > ymax) row_acc = ymax;
    xl = col_acc >> 8;
    yl = row_acc >> 8;
    xh = (xl + 1 < sw) ? xl + 1 : xl;
    yh = (yl + 1 < sh) ? yl + 1 : yl;
    xf = col_acc & 8'hFF;
    yf = row_acc & 8'hFF;
    tl = pixel_at(xl, yl, sw);
    tr = pixel_at(xh, yl, sw);
    bl = pixel_at(xl, yh, sw);
    br = pixel_at(xh, yh, sw);
    for (k = 0; k < 4; k++) begin
      a = (tl >> (8 * k)) & 8'hFF;
      b = (tr >> (8 * k)) & 8'hFF;
      c = (bl >> (8 * k)) & 8'hFF;
      d = (br >> (8 * k)) & 8'hFF;
      top = a * (256 - xf) + b * xf;
      bot = c * (256 - xf) + d * xf;
      tot = top * (256 - yf) + bot * yf;
      v = ((tot + 32'h8000) >> 16) & 8'hFF;
      lanes[k] = (k < ch) ? v[7:0] : 8'h00;
    end
    res.result_ch0 = lanes[0];
    res.result_ch1 = lanes[1];
    res.result_ch2 = lanes[2];
    res.result_ch3 = lanes[3];
    col_cnt++;
    col_acc += step_q88(sw, tw);
    if (col_acc > xmax) col_acc = xmax;
    if (col_cnt >= tw) begin
      res.row_end = 1'b1;
      col_cnt = 0;
      col_acc = 0;
      row_cnt++;
      row_acc += step_q88(sh, th);
      if (row_acc > ymax) row_acc = ymax;
      if (row_cnt >= th) begin
        res.frame_end = 1'b1;
        row_cnt = 0;
        row_acc = 0;
      end
    end
    return 1;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", out_item_o);
      end else begin
        want = pixel_queue.pop_front();
        if (out_item_o.result_ch0 !== want.result_ch0 ||
            out_item_o.result_ch1 !== want.result_ch1 ||
            out_item_o.result_ch2 !== want.result_ch2 ||
            out_item_o.result_ch3 !== want.result_ch3 ||
            out_item_o.row_end !== want.row_end ||
            out_item_o.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h actual %h", want, out_item_o);
        end
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output back-pressure.
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!stall_mode) begin
        out_ready_i <= 1'b1;
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Valid stays high into the next item when there is no gap; drain drops it.
  task automatic send_item(in_item_t it, bit use_gaps);
    out_item_t res;
    int unsigned n;
    n = use_gaps ? gap_len() : 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (scale_pixel(it, res)) pixel_queue.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    predict_config(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned ch);
    drain();
    write_reg(REG_SRC_W, CfgDataW'(sw));
    write_reg(REG_SRC_H, CfgDataW'(sh));
    write_reg(REG_TGT_W, CfgDataW'(tw));
    write_reg(REG_TGT_H, CfgDataW'(th));
    write_reg(REG_CHAN, CfgDataW'(ch));
  endtask

  function automatic in_item_t rand_load();
    in_item_t it;
    it = in_item_t'({OP_LOAD, 32'($urandom)});
    it.operation = OP_LOAD;
    return it;
  endfunction

  // Load a full source frame, then emit a number of pixels.
  task automatic run_frame(int unsigned emits, bit use_gaps);
    in_item_t it;
    int unsigned i;
    for (i = 0; i < clampu(src_w, 1, MaxWidth) * clampu(src_h, 1, MaxHeight); i++)
      send_item(rand_load(), use_gaps);
    it = '0;
    it.operation = OP_EMIT;
    for (i = 0; i < emits; i++) send_item(it, use_gaps);
  endtask

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } step_row_t;

  step_row_t directed [$];

  initial begin
    int unsigned i, r, sent, n;
    mismatches = 0;
    cycles = 0;
    stall_mode = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SRC_W;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    src_w = 64;
    src_h = 64;
    tgt_w = 64;
    tgt_h = 64;
    chan_cnt = 3;
    predictor_restart();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 2x2 source copied to 2x2, extremes and unused lane.
    set_geometry(2, 2, 2, 2, 3);
    directed.push_back('{'{OP_LOAD, 8'hFF, 8'h00, 8'hFF, 8'h00}, 0, '0});
    directed.push_back('{'{OP_LOAD, 8'h00, 8'hFF, 8'h00, 8'hFF}, 0, '0});
    directed.push_back('{'{OP_LOAD, 8'hAA, 8'h55, 8'h12, 8'h34}, 0, '0});
    directed.push_back('{'{OP_LOAD, 8'h01, 8'h80, 8'hFE, 8'h7F}, 0, '0});
    directed.push_back('{'{OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1,
                         '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0}});
    directed.push_back('{'{OP_EMIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1,
                         '{8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0}});
    directed.push_back('{'{OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1,
                         '{8'hAA, 8'h55, 8'h12, 8'h00, 1'b0, 1'b0}});
    directed.push_back('{'{OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 1,
                         '{8'h01, 8'h80, 8'hFE, 8'h00, 1'b1, 1'b1}});
    // Load wrap overwrites the first pixel; upscaling then interpolates.
    directed.push_back('{'{OP_LOAD, 8'h10, 8'h20, 8'h30, 8'h40}, 0, '0});
    for (i = 0; i < 5; i++)
      directed.push_back('{'{OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00}, 0, '0});
    foreach (directed[j]) begin
      send_item(directed[j].stim, 0);
      if (directed[j].known && pixel_queue.size() != 0)
        pixel_queue[pixel_queue.size() - 1] = directed[j].want;
    end
    set_geometry(2, 2, 3, 3, 4);
    run_frame(9, 0);

    // Out-of-range registers: zero and saturated source, zero target, zero and excess channels.
    set_geometry(0, 127, 0, 0, 0);
    run_frame(3, 0);
    set_geometry(1, 1, 1, 1, 7);
    run_frame(2, 0);

    // Random phases with random geometry.
    stall_mode = 1;
    sent = 0;
    r = 0;
    while (sent < 450) begin
      case (r % 6)
        0: set_geometry($urandom_range(1, 6), $urandom_range(1, 6),
                        $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4));
        1: set_geometry($urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 7));
        2: set_geometry($urandom_range(2, 5), $urandom_range(2, 5),
                        65535, $urandom_range(1, 4), $urandom_range(1, 4));
        3: set_geometry($urandom_range(1, 5), $urandom_range(1, 5),
                        $urandom_range(0, 6), $urandom_range(0, 6), 4);
        4: set_geometry(64, 2, $urandom_range(1, 40), 65535, $urandom_range(1, 4));
        default: set_geometry(2, 64, $urandom_range(1, 4), $urandom_range(1, 70), 4);
      endcase
      i = clampu(src_w, 1, MaxWidth) * clampu(src_h, 1, MaxHeight);
      n = $urandom_range(4, 30);
      run_frame(n, 1);
      sent += i + n;
      // Noise: extra loads and emits mixed after the frame is filled.
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 3) == 0) send_item(rand_load(), 1);
        else send_item(in_item_t'({OP_EMIT, 32'($urandom)}), 1);
        sent++;
      end
      if (r == 2) drain();
      r++;
    end

    drain();
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bis_pkg.sv
rtl/core/bis_step_div.sv
rtl/core/bis_front.sv
rtl/core/bis_queue.sv
rtl/core/bis_back.sv
rtl/core/bilinear_image_scaler_core.sv
tb/tb_bilinear_image_scaler_core.sv
